// ===== rtl/core/dvst_pkg.sv =====
// dvst_pkg: shared types and constants of the distinct value set table.
// Used by dvst_front, dvst_queue, dvst_back and distinct_value_set_table_top.
`timescale 1ns / 1ps

package dvst_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KEY_W  = 64;
	localparam int POS_W  = 8;
	localparam int ECNT_W = 9;
	localparam int QDEPTH = 2;

	// request type codes as they arrive on tuser
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_LOOKUP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic              full_reject;
		logic [ECNT_W-1:0] entry_count;
		logic [POS_W-1:0]  position;
		logic              hit;
	} res_t;

endpackage

// ===== rtl/core/dvst_front.sv =====
// dvst_front: input stage; accepts request transactions and decodes the request type.
// Depends on dvst_pkg.
`timescale 1ns / 1ps

module dvst_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                in_type,
	input  logic [dvst_pkg::KEY_W-1:0] in_key,
	output logic                      push_valid,
	input  logic                      push_ready,
	output dvst_pkg::req_t            push_req
);

	logic           v_q;
	dvst_pkg::req_t req_q;
	dvst_pkg::op_t  op_c;

	always_comb begin
		case (in_type)
			dvst_pkg::REQ_INSERT: op_c = dvst_pkg::OP_INSERT;
			dvst_pkg::REQ_REMOVE: op_c = dvst_pkg::OP_REMOVE;
			default:              op_c = dvst_pkg::OP_LOOKUP; // unused code acts as lookup
		endcase
	end

	assign in_ready   = !v_q || push_ready;
	assign push_valid = v_q;
	assign push_req   = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_q <= 1'b1;
		end else if (push_ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q.op  <= op_c;
			req_q.key <= in_key;
		end
	end

endmodule

// ===== rtl/core/dvst_queue.sv =====
// dvst_queue: short request queue between the front and back parts.
// Depends on dvst_pkg.
`timescale 1ns / 1ps

module dvst_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  dvst_pkg::req_t push_req,
	output logic           pop_valid,
	input  logic           pop_ready,
	output dvst_pkg::req_t pop_req
);

	localparam int PTR_W = (dvst_pkg::QDEPTH > 1) ? $clog2(dvst_pkg::QDEPTH) : 1;
	localparam int QC_W  = $clog2(dvst_pkg::QDEPTH + 1);

	dvst_pkg::req_t   slot_q [dvst_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [QC_W-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != QC_W'(dvst_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_req    = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(dvst_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(dvst_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_req;
		end
	end

endmodule

// ===== rtl/core/dvst_back.sv =====
// dvst_back: key table, parallel compare, append / compaction update, result register.
// Depends on dvst_pkg.
`timescale 1ns / 1ps

module dvst_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  dvst_pkg::req_t pop_req,
	output logic           res_valid,
	input  logic           res_ready,
	output dvst_pkg::res_t res
);

	localparam int DEPTH = dvst_pkg::DEPTH;
	localparam int IDX_W = dvst_pkg::IDX_W;
	localparam int CNT_W = dvst_pkg::CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	state_t                    st_q;
	dvst_pkg::req_t            req_s1;
	logic                      hit_s2;
	logic [IDX_W-1:0]          pos_s2;
	logic [dvst_pkg::KEY_W-1:0] entries_q [DEPTH];
	logic [CNT_W-1:0]          fill_q;
	logic                      out_v_q;
	dvst_pkg::res_t            res_q;

	logic [DEPTH-1:0] match_c;
	logic             hit_c;
	logic [IDX_W-1:0] pos_c;
	logic             upd_go;
	logic             is_full;
	logic             ins_do;
	logic             rem_do;
	logic             reject_c;
	logic [CNT_W-1:0] fill_nx;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_c[i] = (entries_q[i] == req_s1.key) && (CNT_W'(i) < fill_q);
		end
		hit_c = |match_c;
		pos_c = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_c[i]) begin
				pos_c = IDX_W'(i);
			end
		end
	end

	assign is_full  = fill_q == CNT_W'(DEPTH);
	assign ins_do   = (req_s1.op == dvst_pkg::OP_INSERT) && !hit_s2 && !is_full;
	assign rem_do   = (req_s1.op == dvst_pkg::OP_REMOVE) && hit_s2;
	assign reject_c = (req_s1.op == dvst_pkg::OP_INSERT) && !hit_s2 && is_full;

	always_comb begin
		fill_nx = fill_q;
		if (ins_do) begin
			fill_nx = fill_q + 1'b1;
		end else if (rem_do) begin
			fill_nx = fill_q - 1'b1;
		end
	end

	assign upd_go    = !out_v_q || res_ready;
	assign pop_ready = (st_q == ST_IDLE) || ((st_q == ST_UPD) && upd_go);
	assign res_valid = out_v_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			fill_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && res_ready && !((st_q == ST_UPD) && upd_go)) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop_valid) begin
						st_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						fill_q  <= fill_nx;
						out_v_q <= 1'b1;
						st_q    <= pop_valid ? ST_CMP : ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			req_s1 <= pop_req;
		end
		if (st_q == ST_CMP) begin
			hit_s2 <= hit_c;
			pos_s2 <= pos_c;
		end
		if ((st_q == ST_UPD) && upd_go) begin
			res_q.hit         <= hit_s2;
			res_q.position    <= hit_s2 ? dvst_pkg::POS_W'(pos_s2) : '0;
			res_q.entry_count <= dvst_pkg::ECNT_W'(fill_nx);
			res_q.full_reject <= reject_c;
			for (int i = 0; i < DEPTH; i++) begin
				if (ins_do && (fill_q == CNT_W'(i))) begin
					entries_q[i] <= req_s1.key;
				end
			end
			// close the gap: every entry from the hit onward takes its upper neighbor
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (rem_do && (IDX_W'(i) >= pos_s2)) begin
					entries_q[i] <= entries_q[i + 1];
				end
			end
		end
	end

`ifndef SYNTH
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count beyond table depth");

	a_upd_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD) |-> ($past(st_q) == ST_CMP || $past(st_q) == ST_UPD))
		else $error("update entered without compare");

	a_fill_only_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> ($past(st_q) == ST_UPD))
		else $error("fill count changed outside update");

	a_reject_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !(res_q.hit && res_q.full_reject))
		else $error("result both hit and rejected");

	a_pos_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !res_q.hit) |-> (res_q.position == '0))
		else $error("position set on a miss");
`endif

endmodule

// ===== rtl/core/distinct_value_set_table_top.sv =====
// distinct_value_set_table_top: top level of the ordered set of distinct 64-bit keys.
// Depends on dvst_pkg, dvst_front, dvst_queue, dvst_back.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request type (insert if
//   absent, remove, lookup; the unused code acts as a lookup), tdata the 64-bit key.
//   Each request gives exactly one result transaction on m_axis: hit, position of the
//   key before the request, entry count after it, and the full-table reject flag.
//   Keys compare as raw bit patterns; a remove shifts later entries down by one.
// Timing:
//   An accepted request on an idle block passes the input register, queue write,
//   request register, compare and update before m_axis_tvalid. The table logic takes
//   the next request in the update state of the last, so each request has a compare
//   and an update state. A 2-entry queue sits between the input stage and the table.
// Reset and stall:
//   arst_n clears the table to empty and drops any queued or pending transactions.
//   When m_axis_tready is low the result register holds; the table finishes its
//   compare, then waits, and the queue and input stage keep taking requests until
//   full, after which s_axis_tready goes low.
`timescale 1ns / 1ps

module distinct_value_set_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] key
	input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [0] hit, [8:1] position, [17:9] entry_count,
	                                   // [18] full_reject, [23:19] zero
);

	logic           push_valid;
	logic           push_ready;
	dvst_pkg::req_t push_req;
	logic           pop_valid;
	logic           pop_ready;
	dvst_pkg::req_t pop_req;
	dvst_pkg::res_t res;

	dvst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_type    (s_axis_tuser),
		.in_key     (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req)
	);

	dvst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_req    (pop_req)
	);

	dvst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_req   (pop_req),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {5'b0, res.full_reject, res.entry_count, res.position, res.hit};

endmodule

// ===== test/distinct_value_set_table_top_tb.sv =====
// distinct_value_set_table_top_tb: stream-level test of the distinct key table.
// Keeps a shadow copy of the key table, predicts every reply and checks it field by field.
// Depends on dvst_pkg and distinct_value_set_table_top.
`timescale 1ns / 1ps

module distinct_value_set_table_top_tb;

	localparam logic [1:0] REQ_UNUSED = 2'd3;   // decoded by the block as a lookup
	localparam int RANDOM_REQS = 1550;
	localparam int PHASE_LEN   = 200;
	localparam int KEY_POOL_N  = 24;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_WAIT  = 20;

	typedef struct {
		logic [1:0]  code;
		logic [63:0] key;
	} table_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // [63:0] key
	logic [1:0]  s_axis_tuser = '0;  // [1:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // [0] hit, [8:1] position, [17:9] entry_count,
	                                 // [18] full_reject, [23:19] zero

	table_request_t pending_requests[$];
	dvst_pkg::res_t predicted_replies[$];
	logic [63:0]    shadow_keys[dvst_pkg::DEPTH];
	int             shadow_count = 0;
	logic [63:0]    key_pool[KEY_POOL_N];
	int             total_requests = 0;
	int             sent_count = 0;
	int             accepted_count = 0;
	int             reply_count = 0;
	int             mismatch_count = 0;
	int             hold_left = 0;
	bit             hold_done = 1'b0;

	distinct_value_set_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// phases rotate: no idling, sender idle, receiver stall, both
	function automatic int idle_pct(input int count, input bit sender);
		case ((count / PHASE_LEN) % 4)
			1: idle_pct = sender ? 59 : 0;
			2: idle_pct = sender ? 0 : 59;
			3: idle_pct = 34;
			default: idle_pct = 0;
		endcase
	endfunction

	// applies one request to the shadow table and returns the reply it must give
	function automatic dvst_pkg::res_t predict_reply(input logic [1:0] code,
			input logic [63:0] key);
		dvst_pkg::res_t r;
		bit   found;
		int   where;
		found = 1'b0;
		where = 0;
		r = '0;
		for (int i = 0; i < shadow_count; i++)
			if (!found && shadow_keys[i] === key) begin
				found = 1'b1;
				where = i;
			end
		r.hit = found;
		r.position = found ? dvst_pkg::POS_W'(where) : '0;
		if (code == dvst_pkg::REQ_INSERT) begin
			if (!found) begin
				if (shadow_count < dvst_pkg::DEPTH) begin
					shadow_keys[shadow_count] = key;
					shadow_count++;
				end else begin
					r.full_reject = 1'b1;
				end
			end
		end else if (code == dvst_pkg::REQ_REMOVE && found) begin
			for (int i = where; i < shadow_count - 1; i++)
				shadow_keys[i] = shadow_keys[i + 1];
			shadow_count--;
		end
		r.entry_count = dvst_pkg::ECNT_W'(shadow_count);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t ns reply %0d %s: expected 0x%0h, got 0x%0h",
			$time, reply_count, field, want, got);
		mismatch_count++;
	endtask

	task automatic add_request(input logic [1:0] code, input logic [63:0] key);
		table_request_t t;
		t.code = code;
		t.key = key;
		pending_requests.push_back(t);
		total_requests++;
	endtask

	// sender: takes the next request when the bus is free
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted_replies.push_back(predict_reply(s_axis_tuser, s_axis_tdata));
				accepted_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_requests.size() > 0 &&
						$urandom_range(99) >= idle_pct(sent_count, 1'b1)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= pending_requests[0].code;
					s_axis_tdata  <= pending_requests[0].key;
					void'(pending_requests.pop_front());
					sent_count++;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off so the queue fills and the input stalls
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && reply_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= (hold_left == 0) &&
				($urandom_range(99) >= idle_pct(reply_count, 1'b0));
	end

	// monitor: every reply transaction against the oldest prediction
	always @(posedge clk) begin
		dvst_pkg::res_t want;
		dvst_pkg::res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = dvst_pkg::res_t'(m_axis_tdata[$bits(dvst_pkg::res_t)-1:0]);
			if (predicted_replies.size() == 0) begin
				report_mismatch("reply with nothing expected", '0, m_axis_tdata);
			end else begin
				want = predicted_replies.pop_front();
				if (got.hit !== want.hit)
					report_mismatch("hit", want.hit, got.hit);
				if (got.position !== want.position)
					report_mismatch("position", want.position, got.position);
				if (got.entry_count !== want.entry_count)
					report_mismatch("entry_count", want.entry_count, got.entry_count);
				if (got.full_reject !== want.full_reject)
					report_mismatch("full_reject", want.full_reject, got.full_reject);
				if (m_axis_tdata[23:19] !== '0)
					report_mismatch("padding", '0, m_axis_tdata[23:19]);
			end
			reply_count++;
		end
	end

	initial begin
		int         r;
		int         ins_pct;
		logic [1:0] code;
		logic [63:0] key;

		key_pool[0] = 64'h0000_0000_0000_0000;   // +0.0
		key_pool[1] = 64'h8000_0000_0000_0000;   // -0.0
		key_pool[2] = 64'h7FF8_0000_0000_0001;   // NaN
		key_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
		for (int i = 4; i < KEY_POOL_N; i++)
			key_pool[i] = {$urandom, $urandom};

		// directed: empty table, signed zeros, NaN, fill to full, reject, removes
		add_request(dvst_pkg::REQ_LOOKUP, key_pool[0]);
		add_request(dvst_pkg::REQ_REMOVE, key_pool[0]);
		add_request(dvst_pkg::REQ_INSERT, key_pool[0]);
		add_request(dvst_pkg::REQ_INSERT, key_pool[1]);
		add_request(dvst_pkg::REQ_INSERT, key_pool[2]);
		add_request(dvst_pkg::REQ_LOOKUP, key_pool[2]);
		add_request(dvst_pkg::REQ_INSERT, key_pool[3]);
		add_request(dvst_pkg::REQ_INSERT, key_pool[0]);
		add_request(REQ_UNUSED, key_pool[1]);
		for (int i = 1; i <= 12; i++)
			add_request(dvst_pkg::REQ_INSERT, 64'(i) * 64'h1111_1111_1111_1111 + 64'd1);
		add_request(dvst_pkg::REQ_INSERT, 64'h0123_4567_89AB_CDEF);
		add_request(dvst_pkg::REQ_INSERT, key_pool[3]);
		add_request(dvst_pkg::REQ_REMOVE, key_pool[1]);
		add_request(dvst_pkg::REQ_REMOVE, 64'd12 * 64'h1111_1111_1111_1111 + 64'd1);
		add_request(dvst_pkg::REQ_REMOVE, key_pool[0]);

		// random: alternate stretches of higher and lower insert share to sweep the fill level
		for (int n = 0; n < RANDOM_REQS; n++) begin
			ins_pct = ((n / 100) % 2) ? 30 : 60;
			r = $urandom_range(99);
			if (r < ins_pct)
				code = dvst_pkg::REQ_INSERT;
			else if (r < ins_pct + 25)
				code = dvst_pkg::REQ_REMOVE;
			else if (r < 95)
				code = dvst_pkg::REQ_LOOKUP;
			else
				code = REQ_UNUSED;
			if ($urandom_range(99) < 85)
				key = key_pool[$urandom_range(KEY_POOL_N - 1)];
			else
				key = {$urandom, $urandom};
			add_request(code, key);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_requests || predicted_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0)
			$display("distinct_value_set_table_top_tb passed");
		else
			$display("distinct_value_set_table_top_tb failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("distinct_value_set_table_top_tb failed");
		$finish;
	end

endmodule
